### rtl/core/periodic_task_dispatcher_defines.svh
// Assertion macros used by the periodic task dispatcher top level.
`ifndef PERIODIC_TASK_DISPATCHER_DEFINES_SVH
`define PERIODIC_TASK_DISPATCHER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PTD_ASSERT_IMP(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define PTD_ASSERT_NXT(lbl, cond, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) else $error(msg);

`endif

### rtl/core/ptd_pkg.sv
// Shared types, codes and helpers of the periodic task dispatcher.
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int SLOT_COUNT_DEFAULT = 16;
  localparam int MAX_RESULTS = 16;
  localparam int DISP_W = $clog2(MAX_RESULTS + 1);
  localparam logic [31:0] OVERRUN_SLACK = 32'd5;

  // Input item kinds.
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_ADD   = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // Result kinds.
  localparam logic [1:0] RK_DISPATCH = 2'd0;
  localparam logic [1:0] RK_IDLE     = 2'd1;
  localparam logic [1:0] RK_ADD      = 2'd2;
  localparam logic [1:0] RK_OVERRUN  = 2'd3;

  // Decoded command handed from the front end to the engine.
  typedef enum logic [1:0] {
    OP_TICK,
    OP_ADD,
    OP_QUERY
  } cmd_op_t;

  // Argument: tick time, {period, offset} for an add, or the queried index.
  typedef struct packed {
    cmd_op_t     op;
    logic [31:0] arg;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  slot_number;
    logic        accepted;
    logic [15:0] overrun_count;
    logic        last;
  } beat_t;

  function automatic beat_t make_beat(input logic [1:0] rk, input logic [3:0] slot,
                                      input logic acc, input logic [15:0] ovr,
                                      input logic fin);
    beat_t b;
    b.result_kind   = rk;
    b.slot_number   = slot;
    b.accepted      = acc;
    b.overrun_count = ovr;
    b.last          = fin;
    return b;
  endfunction

endpackage

### rtl/core/ptd_front.sv
// Front end: accepts input beats, decodes them and queues commands for the engine.
`timescale 1ns / 1ps

module ptd_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    kind,
  input  logic [31:0]   current_time,
  input  logic [15:0]   period,
  input  logic [15:0]   offset,
  input  logic [7:0]    slot_index,
  output logic          cmd_valid,
  output ptd_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import ptd_pkg::*;

  localparam logic [1:0] QUEUE_DEPTH = 2'd2;

  cmd_t       q_mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       in_cmd;
  logic       in_known;
  logic       push;

  // Decode the item; the reserved kind is taken and dropped.
  always_comb begin
    in_cmd.op  = OP_TICK;
    in_cmd.arg = current_time;
    in_known   = 1'b1;
    case (kind)
      KIND_TICK: begin
        in_cmd.op  = OP_TICK;
        in_cmd.arg = current_time;
      end
      KIND_ADD: begin
        in_cmd.op  = OP_ADD;
        in_cmd.arg = {period, offset};
      end
      KIND_QUERY: begin
        in_cmd.op  = OP_QUERY;
        in_cmd.arg = {24'd0, slot_index};
      end
      default: begin
        in_known = 1'b0;
      end
    endcase
  end

  assign in_stall  = (count == QUEUE_DEPTH);
  assign push      = in_valid && !in_stall && in_known;
  assign cmd_valid = (count != 2'd0);
  assign cmd       = q_mem[rd_ptr];

  // Two-entry command queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        q_mem[wr_ptr] <= in_cmd;
        wr_ptr        <= ~wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(cmd_pop);
    end
  end

endmodule

### rtl/core/ptd_back.sv
// Engine: slot table, tick scan, add and query handling, and the output register.
`timescale 1ns / 1ps

module ptd_back #(
  parameter int SLOT_COUNT = ptd_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  input  ptd_pkg::cmd_t  cmd,
  output logic           cmd_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output ptd_pkg::beat_t beat
);
  import ptd_pkg::*;

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W = $clog2(SLOT_COUNT + 1);

  typedef struct packed {
    logic [15:0] period;
    logic [31:0] next_due;
    logic [31:0] last_run;
    logic [15:0] overruns;
  } slot_entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_EVAL,
    S_FIN,
    S_QRD,
    S_QOUT
  } state_t;

  state_t            state;
  slot_entry_t       mem [SLOT_COUNT];
  slot_entry_t       rd_entry;
  logic [IDX_W-1:0]  scan_idx;
  logic [CNT_W-1:0]  slots_used;
  logic [31:0]       tick_time;
  logic              pend_valid;
  logic [IDX_W-1:0]  pend_slot;
  logic [DISP_W-1:0] disp_cnt;

  logic              out_free;
  logic              full;
  logic              query_hit;
  logic              due;
  logic              overrun;
  logic [31:0]       since;
  logic              last_slot;
  logic              cap_hit;
  logic              eval_take;
  slot_entry_t       upd_entry;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  slot_entry_t       mem_wdata;

  // Decisions on the current command and the slot just read.
  always_comb begin
    out_free  = !out_valid || !out_stall;
    full      = (slots_used == CNT_W'(SLOT_COUNT));
    query_hit = (32'(cmd.arg[7:0]) < 32'(slots_used));
    due       = (tick_time >= rd_entry.next_due);
    since     = tick_time - rd_entry.last_run;
    overrun   = (since > (32'(rd_entry.period) + OVERRUN_SLACK));
    last_slot = ((CNT_W'(scan_idx) + CNT_W'(1)) == slots_used);
    cap_hit   = ((disp_cnt + DISP_W'(1)) == DISP_W'(MAX_RESULTS));
    eval_take = (state == S_EVAL) && due && (!pend_valid || out_free);
    cmd_pop   = (state == S_IDLE) && cmd_valid && out_free;

    upd_entry          = rd_entry;
    upd_entry.last_run = tick_time;
    upd_entry.next_due = tick_time + 32'(rd_entry.period);
    upd_entry.overruns = overrun ? (rd_entry.overruns + 16'd1) : rd_entry.overruns;

    mem_we    = 1'b0;
    mem_waddr = scan_idx;
    mem_wdata = upd_entry;
    if (eval_take) begin
      mem_we = 1'b1;
    end else if (cmd_pop && (cmd.op == OP_ADD) && !full) begin
      mem_we             = 1'b1;
      mem_waddr          = slots_used[IDX_W-1:0];
      mem_wdata.period   = cmd.arg[31:16];
      mem_wdata.next_due = 32'(cmd.arg[15:0]);
      mem_wdata.last_run = 32'd0;
      mem_wdata.overruns = 16'd0;
    end
  end

  // Slot table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_entry <= mem[scan_idx];
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      slots_used <= '0;
      pend_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.op)
              OP_TICK: begin
                tick_time  <= cmd.arg;
                pend_valid <= 1'b0;
                disp_cnt   <= '0;
                scan_idx   <= '0;
                if (slots_used == '0) begin
                  out_valid <= 1'b1;
                  beat      <= make_beat(RK_IDLE, 4'd0, 1'b0, 16'd0, 1'b1);
                end else begin
                  state <= S_RD;
                end
              end
              OP_ADD: begin
                out_valid <= 1'b1;
                if (full) begin
                  beat <= make_beat(RK_ADD, 4'd0, 1'b0, 16'd0, 1'b1);
                end else begin
                  beat       <= make_beat(RK_ADD, 4'(slots_used), 1'b1, 16'd0, 1'b1);
                  slots_used <= slots_used + CNT_W'(1);
                end
              end
              OP_QUERY: begin
                if (query_hit) begin
                  scan_idx <= cmd.arg[IDX_W-1:0];
                  state    <= S_QRD;
                end else begin
                  out_valid <= 1'b1;
                  beat      <= make_beat(RK_OVERRUN, 4'd0, 1'b0, 16'd0, 1'b1);
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          // A due slot is held back one step so the final one can carry last.
          if (eval_take) begin
            if (pend_valid) begin
              out_valid <= 1'b1;
              beat      <= make_beat(RK_DISPATCH, 4'(pend_slot), 1'b0, 16'd0, 1'b0);
            end
            pend_valid <= 1'b1;
            pend_slot  <= scan_idx;
            disp_cnt   <= disp_cnt + DISP_W'(1);
            if (last_slot || cap_hit) begin
              state <= S_FIN;
            end else begin
              scan_idx <= scan_idx + IDX_W'(1);
              state    <= S_RD;
            end
          end else if (!due) begin
            if (last_slot) begin
              state <= S_FIN;
            end else begin
              scan_idx <= scan_idx + IDX_W'(1);
              state    <= S_RD;
            end
          end
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            if (pend_valid) begin
              beat <= make_beat(RK_DISPATCH, 4'(pend_slot), 1'b0, 16'd0, 1'b1);
            end else begin
              beat <= make_beat(RK_IDLE, 4'd0, 1'b0, 16'd0, 1'b1);
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        S_QRD: begin
          state <= S_QOUT;
        end
        S_QOUT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            beat      <= make_beat(RK_OVERRUN, 4'd0, 1'b0, rd_entry.overruns, 1'b1);
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher: front end, command queue and engine.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid, in_stall) takes one item per beat: a tick with the
// current time, an add of a periodic slot, or a query of a slot's overrun count.
// Items of the reserved kind are taken and produce nothing.
// The output channel (out_valid, out_stall) returns result beats in item order;
// last marks the final beat of each item. A tick returns one beat per dispatched
// slot (at most sixteen), or one nothing-due beat.
// The engine answers an add or a miss query straight into the output register;
// a hit query first reads its slot (S_QRD, then S_QOUT). A tick scans the used
// slots in order through the single read port of the slot table, reading and
// then evaluating each slot (S_RD, then S_EVAL), and closes in S_FIN.
// A two-entry queue between the front end and the engine lets items be taken
// while a scan runs.
// Reset empties the table and the queue; no clearing pass is needed.
// When the receiver stalls, the result beat is held, the engine pauses at its
// next beat, and the input side stalls once the queue fills.
`include "periodic_task_dispatcher_defines.svh"

module periodic_task_dispatcher #(
  parameter int SLOT_COUNT = ptd_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [31:0] current_time,
  input  logic [15:0] period,
  input  logic [15:0] offset,
  input  logic [7:0]  slot_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  result_kind,
  output logic [3:0]  slot_number,
  output logic        accepted,
  output logic [15:0] overrun_count,
  output logic        last
);
  import ptd_pkg::*;

  logic  cmd_valid;
  logic  cmd_pop;
  cmd_t  cmd;
  beat_t beat;
  logic  single_beat;
  logic  fields_ok;

  // Decode and queue incoming items.
  ptd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .current_time (current_time),
    .period       (period),
    .offset       (offset),
    .slot_index   (slot_index),
    .cmd_valid    (cmd_valid),
    .cmd          (cmd),
    .cmd_pop      (cmd_pop)
  );

  // Carry out queued commands against the slot table.
  ptd_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .beat      (beat)
  );

  assign result_kind   = beat.result_kind;
  assign slot_number   = beat.slot_number;
  assign accepted      = beat.accepted;
  assign overrun_count = beat.overrun_count;
  assign last          = beat.last;

  // Terms checked by the assertions below.
  assign single_beat = out_valid && (result_kind != RK_DISPATCH);
  assign fields_ok   = ((result_kind == RK_OVERRUN) || (overrun_count == 16'd0)) &&
                       ((result_kind == RK_ADD) || !accepted);

  // The engine only takes a command the queue holds.
  `PTD_ASSERT_IMP(a_pop_nonempty, cmd_pop, cmd_valid, "engine popped an empty queue")
  // Every result except a dispatch is the only beat of its item.
  `PTD_ASSERT_IMP(a_single_last, single_beat, last, "single beat not last")
  // Only a query answer carries a count, and only an add answer can accept.
  `PTD_ASSERT_IMP(a_field_use, out_valid, fields_ok, "field used by wrong result kind")
  // A popped command leaves one queue entry free on the next cycle.
  `PTD_ASSERT_NXT(a_pop_frees, cmd_pop, !in_stall, "queue still full after a pop")

endmodule

### dv/tb.sv
// Self-checking testbench for the periodic task dispatcher with a slot-table predictor.
`timescale 1ns / 1ps

module tb;
  import ptd_pkg::*;

  localparam int SLOTS = SLOT_COUNT_DEFAULT;
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS = 225;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  kind = 2'd0;
  logic [31:0] current_time = 32'd0;
  logic [15:0] period = 16'd0;
  logic [15:0] offset = 16'd0;
  logic [7:0]  slot_index = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  result_kind;
  logic [3:0]  slot_number;
  logic        accepted;
  logic [15:0] overrun_count;
  logic        last;

  // Predicted slot table.
  logic [15:0] tbl_period   [SLOTS];
  logic [31:0] tbl_next_due [SLOTS];
  logic [31:0] tbl_last_run [SLOTS];
  logic [15:0] tbl_overruns [SLOTS];
  int          tbl_used = 0;

  // Result beats still owed by the block, oldest first.
  beat_t       pending_beats[$];

  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          in_idle_on = 1'b1;
  bit          out_idle_on = 1'b1;
  logic [31:0] wall_time = 32'd0;

  periodic_task_dispatcher u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .kind          (kind),
    .current_time  (current_time),
    .period        (period),
    .offset        (offset),
    .slot_index    (slot_index),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .slot_number   (slot_number),
    .accepted      (accepted),
    .overrun_count (overrun_count),
    .last          (last)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Idle length: mostly none, often short, now and then long.
  function automatic int unsigned idle_len(input bit enabled);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Updates the slot table for one accepted beat and queues the results it causes.
  task automatic advance_slot_table(input logic [1:0] k, input logic [31:0] t,
                                    input logic [15:0] p, input logic [15:0] o,
                                    input logic [7:0] idx);
    beat_t       b;
    beat_t       held;
    bit          have_held;
    logic [31:0] since;
    int          n;
    int          i;
    b = '0;
    held = '0;
    have_held = 1'b0;
    n = 0;
    case (k)
      KIND_TICK: begin
        for (i = 0; i < tbl_used && n < MAX_RESULTS; i++) begin
          if (t >= tbl_next_due[i]) begin
            since = t - tbl_last_run[i];
            if (since > {16'd0, tbl_period[i]} + OVERRUN_SLACK)
              tbl_overruns[i] = tbl_overruns[i] + 16'd1;
            tbl_last_run[i] = t;
            tbl_next_due[i] = t + {16'd0, tbl_period[i]};
            if (have_held) pending_beats.push_back(held);
            held = '0;
            held.result_kind = RK_DISPATCH;
            held.slot_number = 4'(i);
            have_held = 1'b1;
            n++;
          end
        end
        // The last dispatch closes the tick; with none, one nothing-due beat does.
        if (have_held) begin
          held.last = 1'b1;
          pending_beats.push_back(held);
        end else begin
          b.result_kind = RK_IDLE;
          b.last = 1'b1;
          pending_beats.push_back(b);
        end
      end
      KIND_ADD: begin
        b.result_kind = RK_ADD;
        b.last = 1'b1;
        if (tbl_used < SLOTS) begin
          tbl_period[tbl_used]   = p;
          tbl_next_due[tbl_used] = {16'd0, o};
          tbl_last_run[tbl_used] = 32'd0;
          tbl_overruns[tbl_used] = 16'd0;
          b.slot_number = 4'(tbl_used);
          b.accepted = 1'b1;
          tbl_used++;
        end
        pending_beats.push_back(b);
      end
      KIND_QUERY: begin
        b.result_kind = RK_OVERRUN;
        b.last = 1'b1;
        if (idx < tbl_used) b.overrun_count = tbl_overruns[idx];
        pending_beats.push_back(b);
      end
      default: begin
        // The reserved kind is taken and produces nothing.
      end
    endcase
  endtask

  // Sends one item beat after a random gap and predicts its results on acceptance.
  task automatic send_item(input logic [1:0] k, input logic [31:0] t,
                           input logic [15:0] p, input logic [15:0] o,
                           input logic [7:0] idx);
    int unsigned gap;
    gap = idle_len(in_idle_on);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    kind         <= k;
    current_time <= t;
    period       <= p;
    offset       <= o;
    slot_index   <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_slot_table(k, t, p, o, idx);
  endtask

  // Holds the input side off until every owed result beat has arrived.
  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic send_tick(input logic [31:0] t);
    send_item(KIND_TICK, t, 16'($urandom), 16'($urandom), 8'($urandom));
  endtask

  task automatic send_add(input logic [15:0] p, input logic [15:0] o);
    send_item(KIND_ADD, $urandom, p, o, 8'($urandom));
  endtask

  task automatic send_query(input logic [7:0] idx);
    send_item(KIND_QUERY, $urandom, 16'($urandom), 16'($urandom), idx);
  endtask

  // Empty table: nothing due, queries of unused slots, and the reserved kind.
  task automatic test_empty_table();
    send_tick(32'd0);
    send_query(8'd0);
    send_query(8'd255);
    send_item(KIND_RESERVED, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 8'hFF);
  endtask

  // Period and offset extremes, overruns, and time wrapping past 2^32.
  task automatic test_slot_extremes();
    send_add(16'd0, 16'd0);
    send_add(16'hFFFF, 16'hFFFF);
    send_add(16'd10, 16'd5);
    send_tick(32'd0);
    send_tick(32'd4);
    send_tick(32'd100);
    send_tick(32'hFFFF_FFFF);
    send_query(8'd0);
    send_query(8'd1);
    send_query(8'd2);
    send_tick(32'hFFFF_FFFF);
    send_tick(32'd3);
    wall_time = 32'd3;
    wait_results_drained();
  endtask

  // Mostly advancing time with small steps, plus jumps, steps back and wrap.
  function automatic logic [31:0] next_wall_time(input logic [31:0] now);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return now + $urandom_range(0, 40);
    if (r < 85) return now + $urandom_range(41, 400);
    if (r < 92) return now + $urandom_range(401, 70000);
    if (r < 95) return now - $urandom_range(1, 50);
    if (r < 98) return $urandom;
    return 32'hFFFF_FFFF - $urandom_range(0, 200);
  endfunction

  function automatic logic [15:0] pick_period();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 16'($urandom_range(1, 60));
    if (r < 85) return 16'($urandom_range(61, 2000));
    if (r < 92) return 16'd0;
    if (r < 96) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  // Random mix of ticks, adds and queries with idle modes changing in stretches.
  task automatic test_random_traffic();
    int          counted;
    int unsigned r;
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 40 == 0) begin
        in_idle_on  = ($urandom_range(0, 3) != 0);
        out_idle_on = ($urandom_range(0, 3) != 0);
      end
      if (counted % 60 == 59) wait_results_drained();
      r = $urandom_range(0, 99);
      if (r < 65) begin
        wall_time = next_wall_time(wall_time);
        send_tick(wall_time);
        counted++;
      end else if (r < 75) begin
        send_add(pick_period(), ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                 16'($urandom_range(0, 300)));
        counted++;
      end else if (r < 95) begin
        send_query(($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17)));
        counted++;
      end else begin
        send_item(KIND_RESERVED, $urandom, 16'($urandom), 16'($urandom), 8'($urandom));
      end
    end
    in_idle_on  = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // Full table: refused adds, edge queries, and ticks that dispatch every slot.
  task automatic test_table_full();
    while (tbl_used < SLOTS) send_add(pick_period(), 16'($urandom));
    send_add(16'hFFFF, 16'hFFFF);
    send_add(16'd0, 16'd0);
    send_query(8'd15);
    send_query(8'd16);
    send_query(8'd255);
    wait_results_drained();
    send_tick(32'hFFFF_FFFF);
    send_tick(32'hFFFF_FFFF);
    send_query(8'd15);
    send_tick(32'd0);
  endtask

  // Receiver stall: random stretches high, with idle-free stretches when disabled.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= idle_len(out_idle_on);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Each accepted result beat is compared with the oldest owed beat.
  always @(posedge clk) begin : check_beat
    beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        $error("result beat with none expected: result_kind %0d, slot_number %0d",
               result_kind, slot_number);
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        check_field("result_kind", 32'(want.result_kind), 32'(result_kind));
        check_field("slot_number", 32'(want.slot_number), 32'(slot_number));
        check_field("accepted", 32'(want.accepted), 32'(accepted));
        check_field("overrun_count", 32'(want.overrun_count), 32'(overrun_count));
        check_field("last", 32'(want.last), 32'(last));
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("periodic_task_dispatcher: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Test sequence.
  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_slot_extremes();
    test_random_traffic();
    test_table_full();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_beats.size() == 0) begin
      $display("periodic_task_dispatcher: match");
    end else begin
      $display("periodic_task_dispatcher: mismatch");
    end
    $finish;
  end

endmodule
